// ===== sv/rc5_block_encrypt_unit_assert.svh =====
// Assertion macros shared by the RC5 encrypt unit checkers.
// Each macro expands to one labeled concurrent assertion that is reset-qualified.
`ifndef RC5_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define RC5_BLOCK_ENCRYPT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RC5_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RC5_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rc5_pkg.sv =====
// Shared types, constants and helper functions for the RC5 encrypt unit.
// No dependencies; every other RTL file refers to this package by scope.
package rc5_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned RotW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // Key schedule magic constants.
  localparam logic [WordW-1:0] MagicP = 32'hB7E15163;
  localparam logic [WordW-1:0] MagicQ = 32'h9E3779B9;
  // Fixed rotate used on the round-key half of each mixing step.
  localparam logic [RotW-1:0]  MixRot = 5'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;

  typedef struct packed {
    logic [WordW-1:0] plain_a;
    logic [WordW-1:0] plain_b;
  } plain_t;

  typedef struct packed {
    logic [WordW-1:0] cipher_a;
    logic [WordW-1:0] cipher_b;
  } cipher_t;

  // Operation select for the shared arithmetic unit.
  typedef struct packed {
    logic            mix_add;  // 1: rotl(x + y + z, amt), 0: rotl(x ^ y, amt) + z
    logic [RotW-1:0] amt;
  } alu_op_t;

  // Left rotate of a 32-bit word; an amount of zero leaves the word unchanged.
  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input logic [RotW-1:0] s);
    logic [2*WordW-1:0] t;
    t = {v, v} << s;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

// ===== sv/rc5_block_encrypt_unit.sv =====
// RC5-32/12/16 encrypt unit top level: sequencer, key registers and datapath registers.
// Depends on rc5_pkg, rc5_alu and rc5_rk_mem.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | in_data_i   (plain_a, plain_b)
//   out     | source    | out_valid_o / out_stall_i | out_data_o  (cipher_a, cipher_b)
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A block runs 2*(ROUNDS+1) steps in the shared unit, one half-round per cycle,
// and then S_DONE loads the output register.
// The first block after a key write first runs the key schedule, 3*2*(ROUNDS+1) mixing
// steps in the shared unit, each an S_MIX_A state followed by an S_MIX_B state.
// Reset clears the key registers to zero and marks the schedule as stale.
// A finished result waits in the output register while out_stall_i is high; the next
// block is taken meanwhile, and the unit holds its own result until the register frees.
module rc5_block_encrypt_unit #(
  parameter int unsigned ROUNDS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rc5_pkg::plain_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rc5_pkg::cipher_t              out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rc5_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rc5_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned NumRk  = 2 * (ROUNDS + 1);
  localparam int unsigned RkAw   = $clog2(NumRk);
  localparam int unsigned WordW  = rc5_pkg::WordW;
  localparam logic [RkAw-1:0] LastRk = RkAw'(NumRk - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MIX_A = 3'd1;
  localparam logic [2:0] S_MIX_B = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [1:0] LastPass = 2'd2;

  logic [2:0]                   state_q, state_d;
  logic [rc5_pkg::CfgDataW-1:0] key_low_q, key_low_d;
  logic [rc5_pkg::CfgDataW-1:0] key_high_q, key_high_d;
  logic                         sched_valid_q, sched_valid_d;
  logic                         out_valid_q, out_valid_d;
  rc5_pkg::cipher_t             out_data_q, out_data_d;

  logic [WordW-1:0]             kw_q [4];
  logic [WordW-1:0]             kw_d [4];
  logic [1:0]                   wi_q, wi_d;
  logic [RkAw-1:0]              ri_q, ri_d;
  logic [1:0]                   pass_q, pass_d;
  logic [WordW-1:0]             init_q, init_d;
  logic [WordW-1:0]             ma_q, ma_d;
  logic [WordW-1:0]             mb_q, mb_d;
  logic [WordW-1:0]             da_q, da_d;
  logic [WordW-1:0]             db_q, db_d;

  rc5_pkg::alu_op_t             alu_op;
  logic [WordW-1:0]             alu_x, alu_y, alu_z, alu_res;
  logic [WordW-1:0]             rk_rdata;
  logic [RkAw-1:0]              rk_raddr;
  logic                         rk_we;
  logic [RkAw-1:0]              ri_next;
  logic                         ri_last;
  logic                         run_odd;
  logic                         run_whiten;
  logic [rc5_pkg::RotW-1:0]     mix_amt;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign ri_last    = (ri_q == LastRk);
  assign ri_next    = ri_last ? '0 : ri_q + RkAw'(1);
  assign run_odd    = ri_q[0];
  assign run_whiten = (ri_q[RkAw-1:1] == '0);
  assign mix_amt    = ma_q[rc5_pkg::RotW-1:0] + mb_q[rc5_pkg::RotW-1:0];

  // Operand selection for the shared unit.
  always_comb begin
    alu_op.mix_add = 1'b1;
    alu_op.amt     = '0;
    alu_x          = '0;
    alu_y          = '0;
    alu_z          = '0;
    unique case (state_q)
      S_MIX_A: begin
        // The first pass reads the seeded table value from the running seed.
        alu_op.amt = rc5_pkg::MixRot;
        alu_x      = (pass_q == 2'd0) ? init_q : rk_rdata;
        alu_y      = ma_q;
        alu_z      = mb_q;
      end
      S_MIX_B: begin
        alu_op.amt = mix_amt;
        alu_x      = kw_q[wi_q];
        alu_y      = ma_q;
        alu_z      = mb_q;
      end
      S_RUN: begin
        // The first two steps only whiten: no xor and no rotate.
        alu_op.mix_add = 1'b0;
        alu_x          = run_odd ? db_q : da_q;
        alu_y          = run_whiten ? '0 : (run_odd ? da_q : db_q);
        alu_op.amt     = run_whiten ? '0 :
                         (run_odd ? da_q[rc5_pkg::RotW-1:0] : db_q[rc5_pkg::RotW-1:0]);
        alu_z          = rk_rdata;
      end
      default: begin
        alu_op.mix_add = 1'b1;
      end
    endcase
  end

  rc5_alu u_alu (
    .op_i  (alu_op),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .z_i   (alu_z),
    .res_o (alu_res)
  );

  // Table port control: the address is issued in the cycle before its use.
  always_comb begin
    rk_we    = (state_q == S_MIX_A);
    rk_raddr = ri_q;
    unique case (state_q)
      S_IDLE:  rk_raddr = '0;
      S_MIX_B: rk_raddr = ri_next;
      S_RUN:   rk_raddr = ri_next;
      default: rk_raddr = ri_q;
    endcase
  end

  rc5_rk_mem #(
    .Depth (NumRk),
    .AddrW (RkAw)
  ) u_rk_mem (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (ri_q),
    .wdata_i (alu_res),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  // Sequencer and register updates.
  always_comb begin
    state_d       = state_q;
    key_low_d     = key_low_q;
    key_high_d    = key_high_q;
    sched_valid_d = sched_valid_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;
    kw_d          = kw_q;
    wi_d          = wi_q;
    ri_d          = ri_q;
    pass_d        = pass_q;
    init_d        = init_q;
    ma_d          = ma_q;
    mb_d          = mb_q;
    da_d          = da_q;
    db_d          = db_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          da_d = in_data_i.plain_a;
          db_d = in_data_i.plain_b;
          ri_d = '0;
          if (sched_valid_q) begin
            state_d = S_RUN;
          end else begin
            // Load the key words and start the schedule from the seed.
            kw_d[0] = key_low_q[WordW-1:0];
            kw_d[1] = key_low_q[2*WordW-1:WordW];
            kw_d[2] = key_high_q[WordW-1:0];
            kw_d[3] = key_high_q[2*WordW-1:WordW];
            wi_d    = '0;
            pass_d  = '0;
            init_d  = rc5_pkg::MagicP;
            ma_d    = '0;
            mb_d    = '0;
            state_d = S_MIX_A;
          end
        end
      end
      S_MIX_A: begin
        ma_d    = alu_res;
        state_d = S_MIX_B;
      end
      S_MIX_B: begin
        mb_d       = alu_res;
        kw_d[wi_q] = alu_res;
        wi_d       = wi_q + 2'd1;
        init_d     = init_q + rc5_pkg::MagicQ;
        ri_d       = ri_next;
        state_d    = S_MIX_A;
        if (ri_last) begin
          if (pass_q == LastPass) begin
            sched_valid_d = 1'b1;
            state_d       = S_RUN;
          end else begin
            pass_d = pass_q + 2'd1;
          end
        end
      end
      S_RUN: begin
        if (run_odd) begin
          db_d = alu_res;
        end else begin
          da_d = alu_res;
        end
        ri_d = ri_next;
        if (ri_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_data_d.cipher_a = da_q;
          out_data_d.cipher_b = db_q;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Key register writes mark the schedule stale.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rc5_pkg::RegKeyLow: begin
          key_low_d     = cfg_data_i;
          sched_valid_d = 1'b0;
        end
        rc5_pkg::RegKeyHigh: begin
          key_high_d    = cfg_data_i;
          sched_valid_d = 1'b0;
        end
        default: begin
          sched_valid_d = sched_valid_d;
        end
      endcase
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      key_low_q     <= '0;
      key_high_q    <= '0;
      sched_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      key_low_q     <= key_low_d;
      key_high_q    <= key_high_d;
      sched_valid_q <= sched_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    kw_q       <= kw_d;
    wi_q       <= wi_d;
    ri_q       <= ri_d;
    pass_q     <= pass_d;
    init_q     <= init_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    da_q       <= da_d;
    db_q       <= db_d;
  end

endmodule

// ===== sv/rc5_alu.sv =====
// Shared add / xor / rotate unit used for both key mixing and cipher rounds.
// Depends on rc5_pkg for the operation struct and the rotate function.
module rc5_alu (
  input  rc5_pkg::alu_op_t             op_i,
  input  logic [rc5_pkg::WordW-1:0]    x_i,
  input  logic [rc5_pkg::WordW-1:0]    y_i,
  input  logic [rc5_pkg::WordW-1:0]    z_i,
  output logic [rc5_pkg::WordW-1:0]    res_o
);

  logic [rc5_pkg::WordW-1:0] sum3;
  logic [rc5_pkg::WordW-1:0] xor_rot;

  // Three-operand sum for the key schedule, xor then rotate for the rounds.
  assign sum3    = x_i + y_i + z_i;
  assign xor_rot = rc5_pkg::rotl(x_i ^ y_i, op_i.amt);

  assign res_o = op_i.mix_add ? rc5_pkg::rotl(sum3, op_i.amt) : (xor_rot + z_i);

endmodule

// ===== sv/rc5_rk_mem.sv =====
// Round-key table: one write port and one read port with registered read data.
// Depends on rc5_pkg for the word width.
module rc5_rk_mem #(
  parameter int unsigned Depth = 26,
  parameter int unsigned AddrW = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [rc5_pkg::WordW-1:0]  wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [rc5_pkg::WordW-1:0]  rdata_o
);

  logic [rc5_pkg::WordW-1:0] mem_q [Depth];
  logic [rc5_pkg::WordW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rc5_chk.sv =====
// Port-level checker for the RC5 encrypt unit, attached to the top level by bind.
// Depends on rc5_pkg and the assertion macros in rc5_block_encrypt_unit_assert.svh.
`include "rc5_block_encrypt_unit_assert.svh"

module rc5_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_i,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input rc5_pkg::cipher_t out_data_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_i;

  // After an input transfer the unit is busy with that block.
  `RC5_ASSERT_NXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_i, "not busy after transfer")

  // A result never appears right after an input transfer.
  `RC5_ASSERT_NXT(a_no_early_result, clk_i, rst_ni, in_xfer, !$rose(out_valid_i), "early result")

  // A new result is loaded only while the unit is still busy with its block.
  `RC5_ASSERT_IMP(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_i), $past(in_stall_i), "result without block")

  // A stalled result holds.
  `RC5_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind rc5_block_encrypt_unit rc5_chk u_rc5_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
